// ----- hdl/cnms_pkg.sv -----
// Shared types and constants for the corner non-maximum suppression block.
// No dependencies; every other file of the block but cnms_ram imports this package.
package cnms_pkg;

   localparam int SAMPLE_W = 32;
   localparam int SIZE_W = 11;
   localparam int COORD_W = 10;
   localparam int CALC_W = 14;
   localparam int LINES = 4;
   localparam int WIN = 5;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int MIN_SIZE = 11;
   localparam logic [SIZE_W-1:0] RST_WIDTH = 11'd640;
   localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd480;

   localparam int WIDE_LO = 7;
   localparam int WIDE_HI_X = 4;
   localparam int WIDE_HI_Y = 4;
   localparam int NARROW_LO_X = 6;
   localparam int NARROW_LO_Y = 5;
   localparam int NARROW_HI_X = 3;
   localparam int NARROW_HI_Y = 4;
   localparam int CENTER_LAG_X = 2;
   localparam int WIDE_LAG_Y = 2;
   localparam int NARROW_LAG_Y = 1;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;
   localparam logic [1:0] REG_WIDE = 2'd3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type [WIN-1:0] column_type;
   typedef sample_type [LINES-1:0] line_word_type;

   typedef struct packed {
      logic shift;
      logic wide;
   } win_ctrl_type;

   typedef struct packed {
      logic range_ok;
      logic fend;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
   } meta_type;

endpackage

// ----- hdl/cnms_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cnms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/cnms_window.sv -----
// 5x5 window of strength samples and the peak test on its centre (wide mode) or on row 3, column 2 (narrow mode).
// Depends on cnms_pkg.
module cnms_window
   import cnms_pkg::*;
(
   input  logic         clock,
   input  win_ctrl_type ctrl,
   input  column_type   new_col,
   input  sample_type   threshold,
   output logic         peak,
   output sample_type   centre
);

   sample_type win_ff [WIN][WIN];
   sample_type win_in [WIN][WIN];

   always_comb begin
      for (int r = 0; r < WIN; r++) begin
         for (int k = 0; k < WIN - 1; k++) begin
            win_in[r][k] = win_ff[r][k+1];
         end
         win_in[r][WIN-1] = new_col[r];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         win_ff <= win_in;
      end
   end

   always_comb begin
      logic all_gt;
      logic skip;
      all_gt = 1'b1;
      centre = ctrl.wide ? win_ff[2][2] : win_ff[3][2];
      for (int r = 0; r < WIN; r++) begin
         for (int k = 0; k < WIN; k++) begin
            skip = (ctrl.wide && r == 2 && k == 2) || (!ctrl.wide && r == 3 && k == 2)
                   || (!ctrl.wide && r < 2);
            if (!skip && !($signed(centre) > $signed(win_ff[r][k]))) begin
               all_gt = 1'b0;
            end
         end
      end
      peak = all_gt && ($signed(centre) >= $signed(threshold));
   end

endmodule

// ----- hdl/corner_nonmax_suppression_core.sv -----
// Corner non-maximum suppression core: line store RAM, window and result stage.
// A sample passes stages s1 and s2 and the result register on its way to rsp_*.
// Throughput: one sample per cycle while req_stall is low; the line store takes one read and one write per cycle.
// Reset clears counters, pipeline valids and registers (640, 480, 0, wide).
// Line store and window are not cleared; they are written before they decide a corner.
// Depends on cnms_pkg, cnms_ram and cnms_window.
module corner_nonmax_suppression_core
   import cnms_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [SAMPLE_W-1:0] req_strength,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_corner_found,
   output logic [COORD_W-1:0]        rsp_corner_x,
   output logic [COORD_W-1:0]        rsp_corner_y,
   output logic signed [SAMPLE_W-1:0] rsp_score,
   output logic                      rsp_frame_end,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [SAMPLE_W-1:0]       csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   sample_type        thr_ff;
   logic              wide_ff;

   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;

   logic [CALC_W-1:0] w_ext, h_ext, w_cl, h_cl, x_ext, y_ext;
   logic [CALC_W-1:0] cx_full, cy_full;
   logic              last_col, last_row, range_wide, range_narrow;
   meta_type          meta_new;

   logic          accept;
   logic          s1_valid_ff;
   sample_type    s1_v_ff;
   logic [XW-1:0] s1_x_ff;
   logic [1:0]    s1_slot_ff;
   meta_type      s1_meta_ff;
   logic          s2_valid_ff;
   meta_type      s2_meta_ff;
   logic          en1, en2, out_free;

   logic [$bits(line_word_type)-1:0] rd_data;
   line_word_type rd_word, wr_word;
   column_type    new_col;
   win_ctrl_type  win_ctrl;
   logic          peak;
   sample_type    centre;
   logic          found;

   logic                rsp_valid_ff;
   logic                rsp_found_ff;
   logic [COORD_W-1:0]  rsp_x_ff;
   logic [COORD_W-1:0]  rsp_y_ff;
   sample_type          rsp_score_ff;
   logic                rsp_fend_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         thr_ff <= '0;
         wide_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_WIDTH: begin
               width_ff <= csr_wdata[SIZE_W-1:0];
            end
            REG_HEIGHT: begin
               height_ff <= csr_wdata[SIZE_W-1:0];
            end
            REG_THRESHOLD: begin
               thr_ff <= $signed(csr_wdata);
            end
            REG_WIDE: begin
               wide_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      w_ext = CALC_W'(width_ff);
      h_ext = CALC_W'(height_ff);
      if (w_ext < CALC_W'(MIN_SIZE)) begin
         w_cl = CALC_W'(MIN_SIZE);
      end else if (w_ext > CALC_W'(MAX_WIDTH)) begin
         w_cl = CALC_W'(MAX_WIDTH);
      end else begin
         w_cl = w_ext;
      end
      if (h_ext < CALC_W'(MIN_SIZE)) begin
         h_cl = CALC_W'(MIN_SIZE);
      end else if (h_ext > CALC_W'(MAX_HEIGHT)) begin
         h_cl = CALC_W'(MAX_HEIGHT);
      end else begin
         h_cl = h_ext;
      end
      x_ext = CALC_W'(col_ff);
      y_ext = CALC_W'(row_ff);
      last_col = (x_ext + CALC_W'(1)) >= w_cl;
      last_row = (y_ext + CALC_W'(1)) >= h_cl;
      range_wide = x_ext >= CALC_W'(WIDE_LO) && (x_ext + CALC_W'(WIDE_HI_X)) <= w_cl
                   && y_ext >= CALC_W'(WIDE_LO) && (y_ext + CALC_W'(WIDE_HI_Y)) <= h_cl;
      range_narrow = x_ext >= CALC_W'(NARROW_LO_X)
                     && (x_ext + CALC_W'(NARROW_HI_X)) <= w_cl
                     && y_ext >= CALC_W'(NARROW_LO_Y)
                     && (y_ext + CALC_W'(NARROW_HI_Y)) <= h_cl;
      cx_full = x_ext - CALC_W'(CENTER_LAG_X);
      cy_full = y_ext - (wide_ff ? CALC_W'(WIDE_LAG_Y) : CALC_W'(NARROW_LAG_Y));
      meta_new.range_ok = wide_ff ? range_wide : range_narrow;
      meta_new.fend = last_col && last_row;
      meta_new.cx = cx_full[COORD_W-1:0];
      meta_new.cy = cy_full[COORD_W-1:0];
      col_in = last_col ? '0 : col_ff + XW'(1);
      row_in = last_col ? (last_row ? '0 : row_ff + YW'(1)) : row_ff;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign en2 = !s2_valid_ff || !(s2_meta_ff.range_ok || s2_meta_ff.fend) || out_free;
   assign en1 = !s1_valid_ff || en2;
   assign req_stall = s1_valid_ff && !en1;
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (en1) begin
            s1_valid_ff <= accept;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_v_ff <= req_strength;
         s1_x_ff <= col_ff;
         s1_slot_ff <= row_ff[1:0];
         s1_meta_ff <= meta_new;
      end
      if (en2 && s1_valid_ff) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   cnms_ram #(
      .WIDTH ($bits(line_word_type)),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff && en1),
      .wr_addr (s1_x_ff),
      .wr_data (wr_word),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      logic [1:0] idx;
      rd_word = rd_data;
      wr_word = rd_word;
      wr_word[s1_slot_ff] = s1_v_ff;
      for (int r = 0; r < LINES; r++) begin
         idx = s1_slot_ff + 2'(r);
         new_col[r] = rd_word[idx];
      end
      new_col[WIN-1] = s1_v_ff;
   end

   assign win_ctrl.shift = s1_valid_ff && en1;
   assign win_ctrl.wide = wide_ff;

   cnms_window u_window (
      .clock     (clock),
      .ctrl      (win_ctrl),
      .new_col   (new_col),
      .threshold (thr_ff),
      .peak      (peak),
      .centre    (centre)
   );

   assign found = s2_meta_ff.range_ok && peak;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff && (found || s2_meta_ff.fend);
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_found_ff <= found;
         rsp_x_ff <= found ? s2_meta_ff.cx : '0;
         rsp_y_ff <= found ? s2_meta_ff.cy : '0;
         rsp_score_ff <= found ? centre : '0;
         rsp_fend_ff <= s2_meta_ff.fend;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_corner_found = rsp_found_ff;
   assign rsp_corner_x = rsp_x_ff;
   assign rsp_corner_y = rsp_y_ff;
   assign rsp_score = rsp_score_ff;
   assign rsp_frame_end = rsp_fend_ff;

   a_hold_s1 : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !en1) |=> (s1_valid_ff && $stable(s1_x_ff) && $stable(s1_v_ff)))
      else $error("held stage lost its beat");

   a_found_thr : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_corner_found) |-> ($signed(rsp_score) >= $signed(thr_ff)))
      else $error("corner below threshold");

   a_found_xor_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_corner_found != rsp_frame_end))
      else $error("result beat is neither a corner nor a frame end exclusively");

   a_end_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_corner_found) |-> (rsp_corner_x == '0 && rsp_corner_y == '0
                                            && rsp_score == '0))
      else $error("frame end beat carries coordinates");

endmodule

// ----- verif/cnms_result_checker.sv -----
// Result checker for corner_nonmax_suppression_core: tracks register writes, predicts corners
// from accepted strength beats and compares every accepted result beat in order.
// Depends on cnms_pkg for sample types, widths and register indexes.
module cnms_result_checker
   import cnms_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  sample_type           req_strength,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_corner_found,
   input  logic [COORD_W-1:0]   rsp_corner_x,
   input  logic [COORD_W-1:0]   rsp_corner_y,
   input  sample_type           rsp_score,
   input  logic                 rsp_frame_end,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [SAMPLE_W-1:0]  csr_wdata,
   output int                   error_count,
   output int                   pending_results
);

   localparam int ROW_WORDS = DEF_MAX_WIDTH;

   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      sample_type         score;
      logic               frame_end;
   } corner_result_type;

   sample_type line_mem [LINES*ROW_WORDS];
   sample_type win [WIN][WIN];
   int unsigned col_pos;
   int unsigned row_pos;
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;
   sample_type thr_reg;
   logic wide_reg;
   corner_result_type expected_corners [$];
   int mismatches = 0;

   function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned hi);
      if (v < 11) return 11;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic window_peak(int crow, int first_row, int rows);
      sample_type center;
      int r;
      int k;
      center = win[crow][2];
      if (center < thr_reg) return 1'b0;
      for (r = first_row; r < first_row + rows; r++)
         for (k = 0; k < WIN; k++)
            if (!(r == crow && k == 2) && !(center > win[r][k])) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void predict_corner(sample_type v);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      int r;
      int k;
      corner_result_type res;
      w = clamp_size(width_reg, DEF_MAX_WIDTH);
      h = clamp_size(height_reg, DEF_MAX_HEIGHT);
      x = col_pos;
      y = row_pos;
      res = '0;
      for (r = 0; r < WIN; r++)
         for (k = 0; k < WIN - 1; k++)
            win[r][k] = win[r][k+1];
      for (r = 0; r < LINES; r++)
         win[r][4] = line_mem[((y + r) % LINES) * ROW_WORDS + x];
      win[4][4] = v;
      line_mem[(y % LINES) * ROW_WORDS + x] = v;

      if (wide_reg) begin
         if (x >= 7 && x + 4 <= w && y >= 7 && y + 4 <= h && window_peak(2, 0, 5)) begin
            res.found = 1'b1;
            res.x = x - 2;
            res.y = y - 2;
            res.score = win[2][2];
         end
      end else if (x >= 6 && x + 3 <= w && y >= 5 && y + 4 <= h && window_peak(3, 2, 3)) begin
         res.found = 1'b1;
         res.x = x - 2;
         res.y = y - 1;
         res.score = win[3][2];
      end

      if (x + 1 >= w) begin
         col_pos = 0;
         if (y + 1 >= h) begin
            row_pos = 0;
            res.frame_end = 1'b1;
         end else begin
            row_pos = y + 1;
         end
      end else begin
         col_pos = x + 1;
      end

      if (res.found || res.frame_end) expected_corners.insert(expected_corners.size(), res);
   endfunction

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_result();
      corner_result_type want;
      if (expected_corners.size() == 0) begin
         report_mismatch($sformatf("unexpected beat: found %0b x %0d y %0d score %0d end %0b",
            rsp_corner_found, rsp_corner_x, rsp_corner_y, rsp_score, rsp_frame_end));
         return;
      end
      want = expected_corners.pop_front();
      if (rsp_corner_found !== want.found)
         report_mismatch($sformatf("corner_found got %0b want %0b (want x %0d y %0d)",
            rsp_corner_found, want.found, want.x, want.y));
      if (rsp_corner_x !== want.x)
         report_mismatch($sformatf("corner_x got %0d want %0d", rsp_corner_x, want.x));
      if (rsp_corner_y !== want.y)
         report_mismatch($sformatf("corner_y got %0d want %0d", rsp_corner_y, want.y));
      if (rsp_score !== want.score)
         report_mismatch($sformatf("score got %0d want %0d (x %0d y %0d)",
            rsp_score, want.score, want.x, want.y));
      if (rsp_frame_end !== want.frame_end)
         report_mismatch($sformatf("frame_end got %0b want %0b (x %0d y %0d)",
            rsp_frame_end, want.frame_end, want.x, want.y));
   endtask

   always @(posedge clock) begin : track
      int i;
      if (reset) begin
         for (i = 0; i < LINES * ROW_WORDS; i++) line_mem[i] = '0;
         for (i = 0; i < WIN * WIN; i++) win[i / WIN][i % WIN] = '0;
         col_pos = 0;
         row_pos = 0;
         width_reg = 11'd640;
         height_reg = 11'd480;
         thr_reg = '0;
         wide_reg = 1'b1;
         expected_corners.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_WIDTH: width_reg = csr_wdata[SIZE_W-1:0];
               REG_HEIGHT: height_reg = csr_wdata[SIZE_W-1:0];
               REG_THRESHOLD: thr_reg = csr_wdata;
               REG_WIDE: wide_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_corner(req_strength);
         if (rsp_valid && !rsp_stall) check_result();
      end
      error_count <= mismatches;
      pending_results <= expected_corners.size();
   end

endmodule

// ----- verif/corner_nonmax_suppression_core_tb.sv -----
// Testbench top for corner_nonmax_suppression_core: drives strength frames, register writes
// and result back-pressure, then prints the verdict. Depends on cnms_pkg and cnms_result_checker.
module corner_nonmax_suppression_core_tb;
   import cnms_pkg::*;

   typedef enum int {
      FILL_RANDOM,
      FILL_TIES,
      FILL_SPARSE,
      FILL_EXTREMES,
      FILL_FLAT,
      FILL_SPIKE
   } fill_type;

   localparam sample_type MOST_NEG = 32'h8000_0000;
   localparam sample_type MOST_POS = 32'h7FFF_FFFF;
   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   sample_type req_strength = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_corner_found;
   logic [COORD_W-1:0] rsp_corner_x;
   logic [COORD_W-1:0] rsp_corner_y;
   sample_type rsp_score;
   logic rsp_frame_end;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = REG_WIDTH;
   logic [SAMPLE_W-1:0] csr_wdata = '0;
   int error_count;
   int pending_results;

   logic idle_on = 1'b1;
   logic hold_wanted = 1'b0;
   logic hold_done = 1'b0;
   sample_type spike_value = '0;
   sample_type flat_value = '0;
   int spike_x = 0;
   int spike_y = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   corner_nonmax_suppression_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_strength     (req_strength),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_corner_found (rsp_corner_found),
      .rsp_corner_x     (rsp_corner_x),
      .rsp_corner_y     (rsp_corner_y),
      .rsp_score        (rsp_score),
      .rsp_frame_end    (rsp_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   cnms_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_strength     (req_strength),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_corner_found (rsp_corner_found),
      .rsp_corner_x     (rsp_corner_x),
      .rsp_corner_y     (rsp_corner_y),
      .rsp_score        (rsp_score),
      .rsp_frame_end    (rsp_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_results  (pending_results)
   );

   initial begin
      #3_000_000;
      $display("corner_nonmax_suppression_core_tb: done, errors");
      $finish;
   end

   // result side: random stall, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 7);
         end
      end
   end

   function automatic sample_type make_sample(fill_type fill, int x, int y);
      int pick;
      case (fill)
         FILL_RANDOM: return $urandom;
         FILL_TIES: return sample_type'(int'($urandom_range(4)) - 2);
         FILL_SPARSE: begin
            if ($urandom_range(99) < 5) return $urandom;
            return sample_type'(int'($urandom_range(2000)) - 1000);
         end
         FILL_EXTREMES: begin
            pick = $urandom_range(4);
            case (pick)
               0: return MOST_NEG;
               1: return MOST_POS;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         end
         FILL_FLAT: return flat_value;
         FILL_SPIKE: return (x == spike_x && y == spike_y) ? spike_value : MOST_NEG;
         default: return '0;
      endcase
   endfunction

   task automatic send_sample(sample_type v);
      while (idle_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_strength <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_block(fill_type fill, int w, int count);
      int i;
      for (i = 0; i < count; i++) send_sample(make_sample(fill, i % w, i / w));
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [SAMPLE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(int w, int h, sample_type thr, logic wide);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_WIDE, wide);
      csr_valid <= 1'b0;
   endtask

   task automatic random_frames(int budget);
      int sent;
      int w;
      int h;
      int pick;
      sample_type thr;
      fill_type fill;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(9);
         w = (pick == 0) ? $urandom_range(10) : $urandom_range(11, 24);
         h = (pick == 1) ? $urandom_range(10) : $urandom_range(11, 16);
         case ($urandom_range(5))
            0: thr = MOST_NEG;
            1: thr = MOST_POS;
            2: thr = '0;
            3: thr = $urandom;
            default: thr = int'($urandom_range(200)) - 100;
         endcase
         case ($urandom_range(9))
            0: fill = FILL_RANDOM;
            1: fill = FILL_TIES;
            2: fill = FILL_EXTREMES;
            default: fill = FILL_SPARSE;
         endcase
         program_regs(w, h, thr, $urandom_range(1));
         if (w < 11) w = 11;
         if (h < 11) h = 11;
         send_block(fill, w, w * h);
         wait_drained();
         sent += w * h;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // run on reset registers, then shrink the frame mid-row
      send_block(FILL_RANDOM, 640, 100);
      wait_drained();
      program_regs(11, 11, MOST_NEG, 1'b1);
      send_block(FILL_RANDOM, 11, 111);
      wait_drained();

      spike_x = 5;
      spike_y = 5;
      spike_value = MOST_POS;
      program_regs(11, 11, MOST_NEG, 1'b1);
      send_block(FILL_SPIKE, 11, 121);
      wait_drained();

      // peak equal to threshold
      spike_x = 6;
      spike_y = 6;
      program_regs(11, 11, MOST_POS, 1'b0);
      send_block(FILL_SPIKE, 11, 121);
      wait_drained();

      // peak below threshold
      spike_x = 4;
      spike_y = 4;
      spike_value = '0;
      program_regs(11, 11, 1, 1'b0);
      send_block(FILL_SPIKE, 11, 121);
      wait_drained();

      // flat frame: ties never win
      flat_value = '0;
      program_regs(12, 11, '0, 1'b1);
      send_block(FILL_FLAT, 12, 132);
      wait_drained();

      program_regs(11, 11, MOST_NEG, 1'b1);
      send_block(FILL_EXTREMES, 11, 121);
      wait_drained();

      // widest rows, then cut the row and finish the frame narrow
      program_regs(2047, 0, MOST_NEG, 1'b0);
      send_block(FILL_RANDOM, 1024, 40);
      wait_drained();
      program_regs(0, 0, MOST_NEG, 1'b0);
      send_block(FILL_RANDOM, 11, 111);
      wait_drained();

      // tallest frame, cut short by a height write
      program_regs(11, 2047, '0, 1'b1);
      send_block(FILL_SPARSE, 11, 11 * 12);
      wait_drained();
      program_regs(11, 5, '0, 1'b1);
      send_block(FILL_SPARSE, 11, 11);
      wait_drained();

      // long result hold-off while beats keep coming
      program_regs(11, 11, MOST_NEG, 1'b0);
      hold_wanted <= 1'b1;
      send_block(FILL_RANDOM, 11, 2 * 121);
      wait_drained();

      idle_on <= 1'b0;
      program_regs(20, 14, '0, 1'b1);
      send_block(FILL_SPARSE, 20, 20 * 14);
      wait_drained();
      idle_on <= 1'b1;

      random_frames(RANDOM_ITEMS);
      wait_drained();

      if (error_count == 0 && pending_results == 0) begin
         $display("corner_nonmax_suppression_core_tb: done, clean");
      end else begin
         $display("corner_nonmax_suppression_core_tb: done, errors");
      end
      $finish;
   end

endmodule
